@@ src/mtt_pkg.sv @@
// shared types, codes and helpers of the markup tag tokenizer
package mtt_pkg;

  localparam int CP_W     = 21;
  localparam int EV_W     = 4;
  localparam int MAX_EV   = 4;
  localparam int LANE_W   = $clog2(MAX_EV);
  localparam int CNT_W    = $clog2(MAX_EV + 1);
  localparam int Q_DEPTH  = 4;

  typedef logic [CP_W-1:0] cp_t;
  typedef logic [EV_W-1:0] ev_t;

  // event codes
  localparam ev_t EV_CHAR        = 4'd0;
  localparam ev_t EV_START_TAG   = 4'd1;
  localparam ev_t EV_END_TAG     = 4'd2;
  localparam ev_t EV_COMMENT     = 4'd3;
  localparam ev_t EV_DOCTYPE     = 4'd4;
  localparam ev_t EV_NAME_CHAR   = 4'd5;
  localparam ev_t EV_ATTR_NAME   = 4'd6;
  localparam ev_t EV_ATTR_VALUE  = 4'd7;
  localparam ev_t EV_ATTR_DONE   = 4'd8;
  localparam ev_t EV_DATA_CHAR   = 4'd9;
  localparam ev_t EV_SELF_CLOSE  = 4'd10;
  localparam ev_t EV_QUIRKS      = 4'd11;
  localparam ev_t EV_NAME_SET    = 4'd12;
  localparam ev_t EV_TOKEN_DONE  = 4'd13;

  // open token kinds
  typedef logic [2:0] kind_t;
  localparam kind_t K_NONE    = 3'd0;
  localparam kind_t K_START   = 3'd1;
  localparam kind_t K_END     = 3'd2;
  localparam kind_t K_COMMENT = 3'd3;
  localparam kind_t K_DOCTYPE = 3'd4;

  // characters of interest
  localparam cp_t CH_TAB   = 21'h09;
  localparam cp_t CH_LF    = 21'h0A;
  localparam cp_t CH_FF    = 21'h0C;
  localparam cp_t CH_SPACE = 21'h20;
  localparam cp_t CH_BANG  = 21'h21;
  localparam cp_t CH_DQ    = 21'h22;
  localparam cp_t CH_SQ    = 21'h27;
  localparam cp_t CH_DASH  = 21'h2D;
  localparam cp_t CH_SLASH = 21'h2F;
  localparam cp_t CH_LT    = 21'h3C;
  localparam cp_t CH_EQ    = 21'h3D;
  localparam cp_t CH_GT    = 21'h3E;
  localparam cp_t CH_QUEST = 21'h3F;
  localparam cp_t CH_UP_A  = 21'h41;
  localparam cp_t CH_UP_D  = 21'h44;
  localparam cp_t CH_UP_Z  = 21'h5A;
  localparam cp_t CH_LO_A  = 21'h61;
  localparam cp_t CH_LO_D  = 21'h64;
  localparam cp_t CH_LO_Z  = 21'h7A;
  localparam cp_t CASE_OFS = 21'h20;

  // keyword match progress
  typedef logic [2:0] prog_t;
  localparam prog_t KW_LAST = 3'd6;

  // tokenizer modes
  typedef enum logic [27:0] {
    M_DATA            = 28'd1 << 0,
    M_TAG_OPEN        = 28'd1 << 1,
    M_END_TAG_OPEN    = 28'd1 << 2,
    M_TAG_NAME        = 28'd1 << 3,
    M_BEFORE_ATTR     = 28'd1 << 4,
    M_ATTR_NAME       = 28'd1 << 5,
    M_AFTER_ATTR_NAME = 28'd1 << 6,
    M_BEFORE_VALUE    = 28'd1 << 7,
    M_VALUE_DQ        = 28'd1 << 8,
    M_VALUE_SQ        = 28'd1 << 9,
    M_VALUE_UNQ       = 28'd1 << 10,
    M_AFTER_VALUE_Q   = 28'd1 << 11,
    M_SELF_CLOSING    = 28'd1 << 12,
    M_BOGUS_COMMENT   = 28'd1 << 13,
    M_DECL_OPEN       = 28'd1 << 14,
    M_DECL_DASH       = 28'd1 << 15,
    M_DECL_DOCTYPE    = 28'd1 << 16,
    M_DOCTYPE         = 28'd1 << 17,
    M_BEFORE_DT_NAME  = 28'd1 << 18,
    M_DT_NAME         = 28'd1 << 19,
    M_AFTER_DT_NAME   = 28'd1 << 20,
    M_BOGUS_DOCTYPE   = 28'd1 << 21,
    M_CMT_START       = 28'd1 << 22,
    M_CMT_START_DASH  = 28'd1 << 23,
    M_CMT             = 28'd1 << 24,
    M_CMT_END_DASH    = 28'd1 << 25,
    M_CMT_END         = 28'd1 << 26,
    M_CMT_END_BANG    = 28'd1 << 27
  } mode_t;

  // input item
  typedef struct packed {
    cp_t  code_point;
    logic end_of_text;
  } item_t;

  // result item
  typedef struct packed {
    ev_t  event_res;
    cp_t  event_char;
    logic last_of_run;
  } result_t;

  // all events caused by one character, packed from lane 0
  typedef struct packed {
    logic [MAX_EV-1:0][EV_W-1:0] code;
    logic [MAX_EV-1:0][CP_W-1:0] chr;
    logic [CNT_W-1:0]            cnt;
  } burst_t;

  // expected letter of "doctype" at a given match position
  function automatic cp_t kw_char(input prog_t p);
    cp_t r;
    case (p)
      3'd1:    r = 21'h6F;
      3'd2:    r = 21'h63;
      3'd3:    r = 21'h74;
      3'd4:    r = 21'h79;
      3'd5:    r = 21'h70;
      3'd6:    r = 21'h65;
      default: r = CH_LO_D;
    endcase
    return r;
  endfunction

endpackage

@@ src/mtt_front.sv @@
// tokenizer state machine: classifies each character into a burst of events
module mtt_front (
  input  logic           clk,
  input  logic           rst,
  input  mtt_pkg::item_t item,
  input  logic           push,
  input  logic           full,
  output mtt_pkg::burst_t burst,
  output logic           burst_push
);
  import mtt_pkg::*;

  mode_t mode, mode_next;
  prog_t prog, prog_next;
  kind_t kind, kind_next;

  cp_t  c;
  cp_t  lc;
  logic sp;
  logic alpha;
  logic accept;

  assign c      = item.code_point;
  assign accept = push && !full;
  assign sp     = (c == CH_TAB) || (c == CH_LF) || (c == CH_FF) || (c == CH_SPACE);
  assign alpha  = ((c >= CH_LO_A) && (c <= CH_LO_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  assign lc     = ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? c + CASE_OFS : c;

  // next state and event burst for the current character
  always_comb begin
    mode_next = mode;
    prog_next = prog;
    kind_next = kind;
    burst     = '0;
    case (mode)
      M_TAG_OPEN: begin
        if (c == CH_BANG) begin
          mode_next = M_DECL_OPEN;
        end else if (c == CH_SLASH) begin
          mode_next = M_END_TAG_OPEN;
        end else if (alpha) begin
          burst.code[0] = EV_START_TAG; burst.chr[0] = c; burst.cnt = 3'd1;
          kind_next = K_START;
          mode_next = M_TAG_NAME;
        end else if (c == CH_QUEST) begin
          mode_next = M_BOGUS_COMMENT;
        end else begin
          burst.code[0] = EV_CHAR; burst.chr[0] = CH_LT;
          if (c == CH_LT) begin
            burst.cnt = 3'd1;
            mode_next = M_TAG_OPEN;
          end else begin
            burst.code[1] = EV_CHAR; burst.chr[1] = c; burst.cnt = 3'd2;
            mode_next = M_DATA;
          end
        end
      end
      M_END_TAG_OPEN: begin
        if (alpha) begin
          burst.code[0] = EV_END_TAG; burst.chr[0] = c; burst.cnt = 3'd1;
          kind_next = K_END;
          mode_next = M_TAG_NAME;
        end else begin
          prog_next = '0;
          mode_next = (c == CH_GT) ? M_DATA : M_BOGUS_COMMENT;
        end
      end
      M_TAG_NAME: begin
        if (sp) begin
          mode_next = M_BEFORE_ATTR;
        end else if (c == CH_SLASH) begin
          mode_next = M_SELF_CLOSING;
        end else if (c == CH_GT) begin
          burst.code[0] = EV_TOKEN_DONE; burst.cnt = 3'd1;
          kind_next = K_NONE; mode_next = M_DATA;
        end else begin
          burst.code[0] = EV_NAME_CHAR; burst.chr[0] = c; burst.cnt = 3'd1;
        end
      end
      M_BEFORE_ATTR, M_SELF_CLOSING, M_AFTER_VALUE_Q: begin
        if (mode == M_SELF_CLOSING && c == CH_GT) begin
          burst.code[0] = EV_SELF_CLOSE; burst.code[1] = EV_TOKEN_DONE; burst.cnt = 3'd2;
          kind_next = K_NONE; mode_next = M_DATA;
        end else if (sp) begin
          mode_next = M_BEFORE_ATTR;
        end else if (c == CH_SLASH) begin
          mode_next = M_SELF_CLOSING;
        end else if (c == CH_GT) begin
          burst.code[0] = EV_TOKEN_DONE; burst.cnt = 3'd1;
          kind_next = K_NONE; mode_next = M_DATA;
        end else begin
          burst.code[0] = EV_ATTR_NAME; burst.chr[0] = c; burst.cnt = 3'd1;
          mode_next = M_ATTR_NAME;
        end
      end
      M_ATTR_NAME: begin
        if (sp) begin
          mode_next = M_AFTER_ATTR_NAME;
        end else if (c == CH_SLASH) begin
          burst.code[0] = EV_ATTR_DONE; burst.cnt = 3'd1;
          mode_next = M_SELF_CLOSING;
        end else if (c == CH_EQ) begin
          mode_next = M_BEFORE_VALUE;
        end else if (c == CH_GT) begin
          burst.code[0] = EV_ATTR_DONE; burst.code[1] = EV_TOKEN_DONE; burst.cnt = 3'd2;
          kind_next = K_NONE; mode_next = M_DATA;
        end else begin
          burst.code[0] = EV_ATTR_NAME; burst.chr[0] = c; burst.cnt = 3'd1;
        end
      end
      M_AFTER_ATTR_NAME: begin
        if (sp) begin
          mode_next = mode;
        end else if (c == CH_EQ) begin
          mode_next = M_BEFORE_VALUE;
        end else begin
          // valueless attribute ends before whatever follows
          burst.code[0] = EV_ATTR_DONE;
          if (c == CH_SLASH) begin
            burst.cnt = 3'd1;
            mode_next = M_SELF_CLOSING;
          end else if (c == CH_GT) begin
            burst.code[1] = EV_TOKEN_DONE; burst.cnt = 3'd2;
            kind_next = K_NONE; mode_next = M_DATA;
          end else begin
            burst.code[1] = EV_ATTR_NAME; burst.chr[1] = c; burst.cnt = 3'd2;
            mode_next = M_ATTR_NAME;
          end
        end
      end
      M_BEFORE_VALUE: begin
        if (sp) begin
          mode_next = mode;
        end else if (c == CH_DQ) begin
          mode_next = M_VALUE_DQ;
        end else if (c == CH_SQ) begin
          mode_next = M_VALUE_SQ;
        end else if (c == CH_GT) begin
          burst.code[0] = EV_ATTR_DONE; burst.code[1] = EV_TOKEN_DONE; burst.cnt = 3'd2;
          kind_next = K_NONE; mode_next = M_DATA;
        end else begin
          burst.code[0] = EV_ATTR_VALUE; burst.chr[0] = c; burst.cnt = 3'd1;
          mode_next = M_VALUE_UNQ;
        end
      end
      M_VALUE_DQ, M_VALUE_SQ: begin
        if ((mode == M_VALUE_DQ && c == CH_DQ) || (mode == M_VALUE_SQ && c == CH_SQ)) begin
          burst.code[0] = EV_ATTR_DONE; burst.cnt = 3'd1;
          mode_next = M_AFTER_VALUE_Q;
        end else begin
          burst.code[0] = EV_ATTR_VALUE; burst.chr[0] = c; burst.cnt = 3'd1;
        end
      end
      M_VALUE_UNQ: begin
        if (sp) begin
          burst.code[0] = EV_ATTR_DONE; burst.cnt = 3'd1;
          mode_next = M_BEFORE_ATTR;
        end else if (c == CH_GT) begin
          burst.code[0] = EV_ATTR_DONE; burst.code[1] = EV_TOKEN_DONE; burst.cnt = 3'd2;
          kind_next = K_NONE; mode_next = M_DATA;
        end else begin
          burst.code[0] = EV_ATTR_VALUE; burst.chr[0] = c; burst.cnt = 3'd1;
        end
      end
      M_BOGUS_COMMENT: begin
        if (c == CH_GT) begin
          mode_next = M_DATA;
        end
      end
      M_DECL_OPEN: begin
        if (c == CH_DASH) begin
          mode_next = M_DECL_DASH;
        end else if (c == CH_LO_D || c == CH_UP_D) begin
          prog_next = 3'd1;
          mode_next = M_DECL_DOCTYPE;
        end else begin
          prog_next = '0;
          mode_next = (c == CH_GT) ? M_DATA : M_BOGUS_COMMENT;
        end
      end
      M_DECL_DASH: begin
        if (c == CH_DASH) begin
          burst.code[0] = EV_COMMENT; burst.cnt = 3'd1;
          kind_next = K_COMMENT;
          mode_next = M_CMT_START;
        end else begin
          prog_next = '0;
          mode_next = (c == CH_GT) ? M_DATA : M_BOGUS_COMMENT;
        end
      end
      M_DECL_DOCTYPE: begin
        // one keyword letter per character, case-insensitive
        if (prog != '0 && prog <= KW_LAST && lc == kw_char(prog)) begin
          if (prog == KW_LAST) begin
            prog_next = '0;
            mode_next = M_DOCTYPE;
          end else begin
            prog_next = prog + 3'd1;
          end
        end else begin
          prog_next = '0;
          mode_next = (c == CH_GT) ? M_DATA : M_BOGUS_COMMENT;
        end
      end
      M_DOCTYPE, M_BEFORE_DT_NAME: begin
        if (sp) begin
          mode_next = M_BEFORE_DT_NAME;
        end else begin
          burst.code[0] = EV_DOCTYPE;
          kind_next = K_DOCTYPE;
          if (c == CH_GT) begin
            burst.code[1] = EV_QUIRKS; burst.code[2] = EV_TOKEN_DONE; burst.cnt = 3'd3;
            kind_next = K_NONE; mode_next = M_DATA;
          end else begin
            burst.code[1] = EV_NAME_CHAR; burst.chr[1] = c; burst.cnt = 3'd2;
            mode_next = M_DT_NAME;
          end
        end
      end
      M_DT_NAME: begin
        if (sp) begin
          burst.code[0] = EV_NAME_SET; burst.cnt = 3'd1;
          mode_next = M_AFTER_DT_NAME;
        end else if (c == CH_GT) begin
          burst.code[0] = EV_NAME_SET; burst.code[1] = EV_TOKEN_DONE; burst.cnt = 3'd2;
          kind_next = K_NONE; mode_next = M_DATA;
        end else begin
          burst.code[0] = EV_NAME_CHAR; burst.chr[0] = c; burst.cnt = 3'd1;
        end
      end
      M_AFTER_DT_NAME: begin
        if (sp) begin
          mode_next = mode;
        end else if (c == CH_GT) begin
          burst.code[0] = EV_TOKEN_DONE; burst.cnt = 3'd1;
          kind_next = K_NONE; mode_next = M_DATA;
        end else begin
          burst.code[0] = EV_QUIRKS; burst.cnt = 3'd1;
          mode_next = M_BOGUS_DOCTYPE;
        end
      end
      M_BOGUS_DOCTYPE: begin
        if (c == CH_GT) begin
          burst.code[0] = EV_TOKEN_DONE; burst.cnt = 3'd1;
          kind_next = K_NONE; mode_next = M_DATA;
        end
      end
      M_CMT_START, M_CMT_START_DASH: begin
        if (c == CH_DASH) begin
          mode_next = (mode == M_CMT_START) ? M_CMT_START_DASH : M_CMT_END;
        end else if (c == CH_GT) begin
          burst.code[0] = EV_TOKEN_DONE; burst.cnt = 3'd1;
          kind_next = K_NONE; mode_next = M_DATA;
        end else begin
          mode_next = M_CMT;
          if (mode == M_CMT_START_DASH) begin
            burst.code[0] = EV_DATA_CHAR; burst.chr[0] = CH_DASH;
            burst.code[1] = EV_DATA_CHAR; burst.chr[1] = c; burst.cnt = 3'd2;
          end else begin
            burst.code[0] = EV_DATA_CHAR; burst.chr[0] = c; burst.cnt = 3'd1;
          end
        end
      end
      M_CMT: begin
        if (c == CH_DASH) begin
          mode_next = M_CMT_END_DASH;
        end else begin
          burst.code[0] = EV_DATA_CHAR; burst.chr[0] = c; burst.cnt = 3'd1;
        end
      end
      M_CMT_END_DASH: begin
        if (c == CH_DASH) begin
          mode_next = M_CMT_END;
        end else begin
          burst.code[0] = EV_DATA_CHAR; burst.chr[0] = CH_DASH;
          burst.code[1] = EV_DATA_CHAR; burst.chr[1] = c; burst.cnt = 3'd2;
          mode_next = M_CMT;
        end
      end
      M_CMT_END: begin
        if (c == CH_GT) begin
          burst.code[0] = EV_TOKEN_DONE; burst.cnt = 3'd1;
          kind_next = K_NONE; mode_next = M_DATA;
        end else if (c == CH_BANG) begin
          mode_next = M_CMT_END_BANG;
        end else if (c == CH_DASH) begin
          burst.code[0] = EV_DATA_CHAR; burst.chr[0] = CH_DASH; burst.cnt = 3'd1;
        end else begin
          burst.code[0] = EV_DATA_CHAR; burst.chr[0] = CH_DASH;
          burst.code[1] = EV_DATA_CHAR; burst.chr[1] = CH_DASH;
          burst.code[2] = EV_DATA_CHAR; burst.chr[2] = c; burst.cnt = 3'd3;
          mode_next = M_CMT;
        end
      end
      M_CMT_END_BANG: begin
        if (c == CH_GT) begin
          burst.code[0] = EV_TOKEN_DONE; burst.cnt = 3'd1;
          kind_next = K_NONE; mode_next = M_DATA;
        end else begin
          burst.code[0] = EV_DATA_CHAR; burst.chr[0] = CH_DASH;
          burst.code[1] = EV_DATA_CHAR; burst.chr[1] = CH_DASH;
          burst.code[2] = EV_DATA_CHAR; burst.chr[2] = CH_BANG;
          if (c == CH_DASH) begin
            burst.cnt = 3'd3;
            mode_next = M_CMT_END_DASH;
          end else begin
            burst.code[3] = EV_DATA_CHAR; burst.chr[3] = c; burst.cnt = 3'd4;
            mode_next = M_CMT;
          end
        end
      end
      default: begin
        // data state
        if (c == CH_LT) begin
          mode_next = M_TAG_OPEN;
        end else begin
          burst.code[0] = EV_CHAR; burst.chr[0] = c; burst.cnt = 3'd1;
          mode_next = M_DATA;
        end
      end
    endcase
    // end of text drops any open token
    if (item.end_of_text) begin
      mode_next = M_DATA;
      prog_next = '0;
      kind_next = K_NONE;
    end
  end

  assign burst_push = accept && (burst.cnt != '0);

  // state registers advance on each accepted character
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_DATA;
      prog <= '0;
      kind <= K_NONE;
    end else if (accept) begin
      mode <= mode_next;
      prog <= prog_next;
      kind <= kind_next;
    end
  end

`ifndef SYNTHESIS
  a_eot_to_data: assert property (@(posedge clk) disable iff (rst)
    accept && item.end_of_text |=> mode == M_DATA && prog == '0 && kind == K_NONE)
    else $error("end of text did not return to data state");
  a_prog_only_in_kw: assert property (@(posedge clk) disable iff (rst)
    mode != M_DECL_DOCTYPE |-> prog == '0)
    else $error("keyword progress left set outside keyword match");
  a_tag_kind: assert property (@(posedge clk) disable iff (rst)
    mode == M_TAG_NAME |-> (kind == K_START || kind == K_END))
    else $error("tag name without an open tag token");
`endif

endmodule

@@ src/mtt_queue.sv @@
// small queue of event bursts between the state machine and the serializer
module mtt_queue #(
  parameter int DEPTH = mtt_pkg::Q_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  mtt_pkg::burst_t wr_data,
  input  logic            rd,
  output mtt_pkg::burst_t rd_data,
  output logic            full,
  output logic            empty
);
  import mtt_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  burst_t              store [DEPTH];
  logic [PTR_W-1:0]    wptr;
  logic [PTR_W-1:0]    rptr;
  logic [CNT_QW-1:0]   count;

  assign full    = (count == CNT_QW'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = store[rptr];

  // burst storage
  always_ff @(posedge clk) begin
    if (wr) begin
      store[wptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> !full || rd)
    else $error("burst written into a full queue");
`endif

endmodule

@@ src/mtt_back.sv @@
// serializer: hands out the events of the head burst one transfer at a time
module mtt_back (
  input  logic             clk,
  input  logic             rst,
  input  mtt_pkg::burst_t  head,
  input  logic             q_empty,
  output logic             q_pop,
  output mtt_pkg::result_t result,
  output logic             empty,
  input  logic             pop
);
  import mtt_pkg::*;

  logic [LANE_W-1:0] sel;
  logic              last;

  assign last                = ({1'b0, sel} == head.cnt - 1'b1);
  assign empty               = q_empty;
  assign result.event_res    = head.code[sel];
  assign result.event_char   = head.chr[sel];
  assign result.last_of_run  = last;
  assign q_pop               = pop && !q_empty && last;

  // lane select within the head burst
  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= '0;
    end else if (pop && !q_empty) begin
      sel <= last ? '0 : sel + 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_sel_in_burst: assert property (@(posedge clk) disable iff (rst)
    !q_empty |-> ({1'b0, sel} < head.cnt))
    else $error("lane select beyond head burst");
`endif

endmodule

@@ src/markup_tag_tokenizer.sv @@
// top level of the markup tag tokenizer
//
// Input channel: one character (code_point, end_of_text) per transfer on item,
// taken at a clock edge with push high and full low. Full stays low as long
// as the burst queue has room, so a character can be taken in every cycle.
// Result channel: event records on result, offered while empty is low and
// taken at a clock edge with pop high. Each character yields zero to four
// events; last_of_run marks the final event of one character, and a
// character that yields none produces no transfer.
// Each burst is registered in the queue before its first event is offered.
// The state machine takes one character per cycle while full is low; events
// leave at one per cycle while pop is high, set by the serializer; a queue of
// QUEUE_DEPTH bursts absorbs runs of several events per character.
// When the receiver stalls, the queue fills and full rises; nothing is lost.
// Reset (rst, synchronous) returns the tokenizer to the data state and
// empties the queue. After a character with end_of_text, its events come
// out and the tokenizer is back in the data state with no open token.
module markup_tag_tokenizer #(
  parameter int QUEUE_DEPTH = mtt_pkg::Q_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  mtt_pkg::item_t   item,
  input  logic             push,
  output logic             full,
  output mtt_pkg::result_t result,
  output logic             empty,
  input  logic             pop
);
  import mtt_pkg::*;

  burst_t front_burst;
  burst_t head;
  logic   burst_push;
  logic   q_pop;
  logic   q_empty;

  // classify characters
  mtt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push       (push),
    .full       (full),
    .burst      (front_burst),
    .burst_push (burst_push)
  );

  // decouple the two sides
  mtt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (burst_push),
    .wr_data (front_burst),
    .rd      (q_pop),
    .rd_data (head),
    .full    (full),
    .empty   (q_empty)
  );

  // emit events one at a time
  mtt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule

@@ bench/tb_top.sv @@
// self-checking testbench for the markup tag tokenizer, with driver, monitor and event predictor
`timescale 1ns / 1ps

module tb_top;
  import mtt_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_CHARS = 430;
  localparam int SETTLE       = 16;

  logic    clk   = 1'b0;
  logic    rst   = 1'b1;
  item_t   item  = '0;
  logic    push  = 1'b0;
  logic    full;
  result_t result;
  logic    empty;
  logic    pop   = 1'b0;

  markup_tag_tokenizer dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .push   (push),
    .full   (full),
    .result (result),
    .empty  (empty),
    .pop    (pop)
  );

  // clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // characters waiting to be sent and events still owed by the block
  item_t   text_chars[$];
  result_t expected_events[$];
  result_t step_events[$];
  cp_t     frag[$];

  int mismatches     = 0;
  int chars_sent     = 0;
  int events_checked = 0;
  int random_chars   = 0;
  int full_cycles    = 0;
  int cycles         = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int hold_clock     = 0;
  int hold_left      = 0;
  int holds_done     = 0;

  string keyword = "doctype";
  cp_t special_chars [14] = '{CH_TAB, CH_LF, CH_FF, CH_SPACE, CH_LT, CH_GT, CH_SLASH,
                              CH_EQ, CH_DQ, CH_SQ, CH_DASH, CH_BANG, CH_QUEST, cp_t'("&")};

  // tokenizer state as the bench sees it
  mode_t tok_mode  = M_DATA;
  prog_t kw_pos    = '0;
  kind_t open_kind = K_NONE;

  // ---------------------------------------------------------------- predictor

  function automatic bit is_space(cp_t c);
    return c == CH_TAB || c == CH_LF || c == CH_FF || c == CH_SPACE;
  endfunction

  function automatic bit is_letter(cp_t c);
    return (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
  endfunction

  function automatic void emit(ev_t code, cp_t ch);
    result_t r;
    r.event_res   = code;
    r.event_char  = ch;
    r.last_of_run = 1'b0;
    if (step_events.size() < MAX_EV) step_events.insert(step_events.size(), r);
  endfunction

  function automatic void token_done();
    emit(EV_TOKEN_DONE, '0);
    open_kind = K_NONE;
    tok_mode  = M_DATA;
  endfunction

  function automatic void open_token(kind_t kind, ev_t code, cp_t ch);
    emit(code, ch);
    open_kind = kind;
  endfunction

  function automatic void in_data(cp_t c);
    if (c == CH_LT) tok_mode = M_TAG_OPEN;
    else emit(EV_CHAR, c);
  endfunction

  // shared by the states that wait for the next attribute name
  function automatic void attr_gap(cp_t c);
    if (is_space(c)) tok_mode = M_BEFORE_ATTR;
    else if (c == CH_SLASH) tok_mode = M_SELF_CLOSING;
    else if (c == CH_GT) token_done();
    else begin
      emit(EV_ATTR_NAME, c);
      tok_mode = M_ATTR_NAME;
    end
  endfunction

  function automatic void doctype_name_start(cp_t c);
    if (is_space(c)) begin
      tok_mode = M_BEFORE_DT_NAME;
      return;
    end
    open_token(K_DOCTYPE, EV_DOCTYPE, '0);
    if (c == CH_GT) begin
      emit(EV_QUIRKS, '0);
      token_done();
    end else begin
      emit(EV_NAME_CHAR, c);
      tok_mode = M_DT_NAME;
    end
  endfunction

  function automatic void go_bogus(cp_t c);
    kw_pos   = '0;
    tok_mode = (c == CH_GT) ? M_DATA : M_BOGUS_COMMENT;
  endfunction

  // advance the tokenizer by one character and queue the events it causes
  function automatic void tokenize_char(item_t it);
    cp_t c;
    cp_t lc;
    c = it.code_point;
    step_events.delete();
    case (tok_mode)
      M_TAG_OPEN: begin
        if (c == CH_BANG) tok_mode = M_DECL_OPEN;
        else if (c == CH_SLASH) tok_mode = M_END_TAG_OPEN;
        else if (is_letter(c)) begin
          open_token(K_START, EV_START_TAG, c);
          tok_mode = M_TAG_NAME;
        end else if (c == CH_QUEST) tok_mode = M_BOGUS_COMMENT;
        else begin
          emit(EV_CHAR, CH_LT);
          tok_mode = M_DATA;
          in_data(c);
        end
      end
      M_END_TAG_OPEN: begin
        if (is_letter(c)) begin
          open_token(K_END, EV_END_TAG, c);
          tok_mode = M_TAG_NAME;
        end else go_bogus(c);
      end
      M_TAG_NAME: begin
        if (is_space(c)) tok_mode = M_BEFORE_ATTR;
        else if (c == CH_SLASH) tok_mode = M_SELF_CLOSING;
        else if (c == CH_GT) token_done();
        else emit(EV_NAME_CHAR, c);
      end
      M_BEFORE_ATTR, M_SELF_CLOSING: begin
        if (tok_mode == M_SELF_CLOSING && c == CH_GT) begin
          emit(EV_SELF_CLOSE, '0);
          token_done();
        end else attr_gap(c);
      end
      M_ATTR_NAME: begin
        if (is_space(c)) tok_mode = M_AFTER_ATTR_NAME;
        else if (c == CH_SLASH) begin
          emit(EV_ATTR_DONE, '0);
          tok_mode = M_SELF_CLOSING;
        end else if (c == CH_EQ) tok_mode = M_BEFORE_VALUE;
        else if (c == CH_GT) begin
          emit(EV_ATTR_DONE, '0);
          token_done();
        end else emit(EV_ATTR_NAME, c);
      end
      M_AFTER_ATTR_NAME: begin
        if (!is_space(c)) begin
          if (c == CH_EQ) tok_mode = M_BEFORE_VALUE;
          else begin
            emit(EV_ATTR_DONE, '0);
            attr_gap(c);
          end
        end
      end
      M_BEFORE_VALUE: begin
        if (!is_space(c)) begin
          if (c == CH_DQ) tok_mode = M_VALUE_DQ;
          else if (c == CH_SQ) tok_mode = M_VALUE_SQ;
          else if (c == CH_GT) begin
            emit(EV_ATTR_DONE, '0);
            token_done();
          end else begin
            emit(EV_ATTR_VALUE, c);
            tok_mode = M_VALUE_UNQ;
          end
        end
      end
      M_VALUE_DQ, M_VALUE_SQ: begin
        if ((tok_mode == M_VALUE_DQ && c == CH_DQ) || (tok_mode == M_VALUE_SQ && c == CH_SQ)) begin
          emit(EV_ATTR_DONE, '0);
          tok_mode = M_AFTER_VALUE_Q;
        end else emit(EV_ATTR_VALUE, c);
      end
      M_VALUE_UNQ: begin
        if (is_space(c)) begin
          emit(EV_ATTR_DONE, '0);
          tok_mode = M_BEFORE_ATTR;
        end else if (c == CH_GT) begin
          emit(EV_ATTR_DONE, '0);
          token_done();
        end else emit(EV_ATTR_VALUE, c);
      end
      M_AFTER_VALUE_Q: attr_gap(c);
      M_BOGUS_COMMENT: begin
        if (c == CH_GT) tok_mode = M_DATA;
      end
      M_DECL_OPEN: begin
        if (c == CH_DASH) tok_mode = M_DECL_DASH;
        else if (c == CH_LO_D || c == CH_UP_D) begin
          kw_pos   = 3'd1;
          tok_mode = M_DECL_DOCTYPE;
        end else go_bogus(c);
      end
      M_DECL_DASH: begin
        if (c == CH_DASH) begin
          open_token(K_COMMENT, EV_COMMENT, '0);
          tok_mode = M_CMT_START;
        end else go_bogus(c);
      end
      M_DECL_DOCTYPE: begin
        lc = (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
        if (kw_pos >= 3'd1 && kw_pos <= KW_LAST && lc == cp_t'(keyword[kw_pos])) begin
          if (kw_pos == KW_LAST) begin
            kw_pos   = '0;
            tok_mode = M_DOCTYPE;
          end else kw_pos = kw_pos + 3'd1;
        end else go_bogus(c);
      end
      M_DOCTYPE: begin
        if (is_space(c)) tok_mode = M_BEFORE_DT_NAME;
        else doctype_name_start(c);
      end
      M_BEFORE_DT_NAME: doctype_name_start(c);
      M_DT_NAME: begin
        if (is_space(c)) begin
          emit(EV_NAME_SET, '0);
          tok_mode = M_AFTER_DT_NAME;
        end else if (c == CH_GT) begin
          emit(EV_NAME_SET, '0);
          token_done();
        end else emit(EV_NAME_CHAR, c);
      end
      M_AFTER_DT_NAME: begin
        if (!is_space(c)) begin
          if (c == CH_GT) token_done();
          else begin
            emit(EV_QUIRKS, '0);
            tok_mode = M_BOGUS_DOCTYPE;
          end
        end
      end
      M_BOGUS_DOCTYPE: begin
        if (c == CH_GT) token_done();
      end
      M_CMT_START, M_CMT_START_DASH: begin
        if (c == CH_DASH) tok_mode = (tok_mode == M_CMT_START) ? M_CMT_START_DASH : M_CMT_END;
        else if (c == CH_GT) token_done();
        else begin
          if (tok_mode == M_CMT_START_DASH) emit(EV_DATA_CHAR, CH_DASH);
          emit(EV_DATA_CHAR, c);
          tok_mode = M_CMT;
        end
      end
      M_CMT: begin
        if (c == CH_DASH) tok_mode = M_CMT_END_DASH;
        else emit(EV_DATA_CHAR, c);
      end
      M_CMT_END_DASH: begin
        if (c == CH_DASH) tok_mode = M_CMT_END;
        else begin
          emit(EV_DATA_CHAR, CH_DASH);
          emit(EV_DATA_CHAR, c);
          tok_mode = M_CMT;
        end
      end
      M_CMT_END: begin
        if (c == CH_GT) token_done();
        else if (c == CH_BANG) tok_mode = M_CMT_END_BANG;
        else if (c == CH_DASH) emit(EV_DATA_CHAR, CH_DASH);
        else begin
          emit(EV_DATA_CHAR, CH_DASH);
          emit(EV_DATA_CHAR, CH_DASH);
          emit(EV_DATA_CHAR, c);
          tok_mode = M_CMT;
        end
      end
      M_CMT_END_BANG: begin
        if (c == CH_GT) token_done();
        else begin
          emit(EV_DATA_CHAR, CH_DASH);
          emit(EV_DATA_CHAR, CH_DASH);
          emit(EV_DATA_CHAR, CH_BANG);
          if (c == CH_DASH) tok_mode = M_CMT_END_DASH;
          else begin
            emit(EV_DATA_CHAR, c);
            tok_mode = M_CMT;
          end
        end
      end
      default: begin
        tok_mode = M_DATA;
        in_data(c);
      end
    endcase

    // mark the final event of this character, then hand the run over
    if (step_events.size() > 0) step_events[step_events.size()-1].last_of_run = 1'b1;
    foreach (step_events[i]) expected_events.insert(expected_events.size(), step_events[i]);

    // end of text drops any open token
    if (it.end_of_text) begin
      tok_mode  = M_DATA;
      kw_pos    = '0;
      open_kind = K_NONE;
    end
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic cp_t rand_letter();
    cp_t base;
    base = $urandom_range(0, 1) ? CH_UP_A : CH_LO_A;
    return base + cp_t'($urandom_range(0, 25));
  endfunction

  function automatic cp_t rand_space();
    return special_chars[$urandom_range(0, 3)];
  endfunction

  function automatic cp_t rand_any();
    case ($urandom_range(0, 9))
      0, 1:    return cp_t'($urandom);
      2, 3, 4: return special_chars[$urandom_range(0, 13)];
      5:       return $urandom_range(0, 1) ? cp_t'(21'h0B) : cp_t'(21'h0D);
      default: return rand_letter();
    endcase
  endfunction

  // append one character to the fragment being built
  function automatic void frag_add(cp_t ch);
    frag.insert(frag.size(), ch);
  endfunction

  task automatic frag_text(string s);
    for (int i = 0; i < s.len(); i++) frag_add(cp_t'(s[i]));
  endtask

  task automatic frag_name(int n);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) frag_add(cp_t'("0") + cp_t'($urandom_range(0, 9)));
      else frag_add(rand_letter());
    end
  endtask

  task automatic frag_value(int n);
    repeat (n) frag_add($urandom_range(0, 3) == 0 ? rand_any() : rand_letter());
  endtask

  // ending 0: as is, 1: end of text on the last char, 2: random cut or end of text
  task automatic queue_frag(int ending);
    item_t it;
    int keep;
    bit eot;
    keep = frag.size();
    eot  = (ending == 1);
    if (ending == 2) begin
      if (keep > 1 && $urandom_range(0, 11) == 0) begin
        keep = $urandom_range(1, keep - 1);
        eot  = 1'b1;
      end else eot = ($urandom_range(0, 9) == 0);
    end
    for (int i = 0; i < keep; i++) begin
      it.code_point  = frag[i];
      it.end_of_text = eot && (i == keep - 1);
      text_chars.insert(text_chars.size(), it);
    end
    if (ending == 2) random_chars += keep;
    frag.delete();
  endtask

  task automatic build_text();
    repeat ($urandom_range(1, 6)) frag_add(rand_any());
  endtask

  task automatic build_tag();
    int kind;
    frag_add(CH_LT);
    if ($urandom_range(0, 3) == 0) begin
      frag_add(CH_SLASH);
      frag_name($urandom_range(1, 4));
      if ($urandom_range(0, 3) == 0) frag_add(rand_space());
      frag_add(CH_GT);
      return;
    end
    frag_name($urandom_range(1, 4));
    repeat ($urandom_range(0, 3)) begin
      frag_add(rand_space());
      if ($urandom_range(0, 5) == 0) frag_add(rand_space());
      if ($urandom_range(0, 7) == 0) frag_add(CH_SLASH);
      frag_name($urandom_range(1, 3));
      kind = $urandom_range(0, 5);
      if (kind != 0) begin
        if ($urandom_range(0, 3) == 0) frag_add(rand_space());
        frag_add(CH_EQ);
        if ($urandom_range(0, 3) == 0) frag_add(rand_space());
        case (kind)
          1, 2: begin
            frag_add(CH_DQ);
            frag_value($urandom_range(0, 3));
            frag_add(CH_DQ);
          end
          3: begin
            frag_add(CH_SQ);
            frag_value($urandom_range(0, 3));
            frag_add(CH_SQ);
          end
          4: frag_value($urandom_range(1, 3));
          default: ;
        endcase
      end
    end
    case ($urandom_range(0, 5))
      0: frag_add(rand_space());
      1: frag_add(CH_SLASH);
      2: frag_text("/ ");
      default: ;
    endcase
    frag_add(CH_GT);
  endtask

  task automatic build_comment();
    frag_text("<!--");
    case ($urandom_range(0, 7))
      0: frag_add(CH_GT);
      1: frag_text("->");
      default: begin
        repeat ($urandom_range(0, 4)) begin
          case ($urandom_range(0, 6))
            0, 1, 2: frag_add(rand_any());
            3: frag_text("-x");
            4: frag_text("--y");
            5: frag_text("--!z");
            default: frag_text("--!-");
          endcase
        end
        case ($urandom_range(0, 3))
          0: frag_text("--!>");
          1: frag_text("--->");
          default: frag_text("-->");
        endcase
      end
    endcase
  endtask

  task automatic build_doctype();
    int cut;
    cp_t ch;
    frag_text("<!");
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 7;
    for (int i = 0; i < 7; i++) begin
      if (i == cut) begin
        frag_add(rand_any());
        frag_add(CH_GT);
        return;
      end
      ch = cp_t'(keyword[i]);
      frag_add($urandom_range(0, 1) ? ch - CASE_OFS : ch);
    end
    if ($urandom_range(0, 5) == 0) begin
      frag_add(CH_GT);
      return;
    end
    repeat ($urandom_range(0, 2)) frag_add(rand_space());
    if ($urandom_range(0, 5) == 0) begin
      frag_add(CH_GT);
      return;
    end
    frag_name($urandom_range(1, 5));
    case ($urandom_range(0, 3))
      0: frag_add(CH_GT);
      1: begin
        frag_add(rand_space());
        frag_add(CH_GT);
      end
      2: begin
        frag_add(rand_space());
        frag_name($urandom_range(1, 3));
        frag_add(CH_GT);
      end
      default: begin
        frag_add(rand_space());
        frag_add(rand_space());
        frag_add(CH_GT);
      end
    endcase
  endtask

  task automatic build_bogus();
    case ($urandom_range(0, 2))
      0: frag_text("<?");
      1: frag_text("</");
      default: frag_text("<!");
    endcase
    frag_add(rand_any());
    frag_name($urandom_range(0, 3));
    frag_add(CH_GT);
  endtask

  // ---------------------------------------------------------------- driver

  function automatic int idle_len(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // offer characters; pick a new gap after each transfer
  always @(posedge clk) begin
    if (rst) begin
      push     <= 1'b0;
      gap_left = 0;
    end else begin
      if (push && full) full_cycles++;
      if (push && !full) begin
        tokenize_char(text_chars.pop_front());
        chars_sent++;
        gap_left = idle_len((chars_sent % 100) < 25 || hold_left != 0);
      end
      if (!(push && full)) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (text_chars.size() > 0) begin
          push <= 1'b1;
          item <= text_chars[0];
        end else push <= 1'b0;
      end
    end
  end

  // long receiver hold-offs so the block fills and stalls its input
  always @(posedge clk) begin
    if (rst) begin
      hold_clock <= 0;
      hold_left  <= 0;
    end else begin
      hold_clock <= hold_clock + 1;
      if (hold_left != 0) hold_left <= hold_left - 1;
      else if (hold_clock == 300 || hold_clock == 1100) begin
        hold_left  <= 200;
        holds_done <= holds_done + 1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 25) $display("MISMATCH at cycle %0d: %s", cycles, msg);
  endtask

  result_t want;

  // check each event transfer against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      pop        <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        if (expected_events.size() == 0)
          report($sformatf("unexpected event %0d char %h", result.event_res, result.event_char));
        else begin
          want = expected_events.pop_front();
          if (result.event_res !== want.event_res)
            report($sformatf("event %0d: code %0d, expected %0d",
                             events_checked, result.event_res, want.event_res));
          if (result.event_char !== want.event_char)
            report($sformatf("event %0d: char %h, expected %h",
                             events_checked, result.event_char, want.event_char));
          if (result.last_of_run !== want.last_of_run)
            report($sformatf("event %0d: last flag %b, expected %b",
                             events_checked, result.last_of_run, want.last_of_run));
        end
        events_checked++;
        stall_left = idle_len((events_checked % 120) < 30);
      end
      if (hold_left != 0) pop <= 1'b0;
      else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else pop <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- run control

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d events still expected",
             cycles, expected_events.size());
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    // directed: extreme code points, end of text, bogus and edge openings
    frag_add(cp_t'(21'h1FFFFF));
    queue_frag(0);
    frag_add('0);
    queue_frag(1);
    frag_text("<?>");
    queue_frag(0);
    frag_text("</>");
    queue_frag(0);
    frag_text("< ");
    queue_frag(0);
    frag_text("<!-->");
    queue_frag(0);
    frag_text("<A/>");
    queue_frag(0);
    frag_text("<!>");
    queue_frag(0);
    frag_text("<a");
    queue_frag(1);

    // random: mostly well-formed markup with random content, some noise
    while (random_chars < RANDOM_CHARS) begin
      case ($urandom_range(0, 99)) inside
        [0:19]:  build_text();
        [20:49]: build_tag();
        [50:64]: build_comment();
        [65:79]: build_doctype();
        [80:87]: build_bogus();
        default: build_text();
      endcase
      queue_frag(2);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (text_chars.size() != 0 || push || expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (expected_events.size() != 0)
      report($sformatf("%0d expected events never arrived", expected_events.size()));
    $display("sent %0d characters, checked %0d events in %0d cycles",
             chars_sent, events_checked, cycles);
    $display("%0d receiver hold-offs, input stalled by full for %0d cycles",
             holds_done, full_cycles);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
src/mtt_pkg.sv
src/mtt_front.sv
src/mtt_queue.sv
src/mtt_back.sv
src/markup_tag_tokenizer.sv
bench/tb_top.sv
